/* rtl/alid_pkg.sv */
// ----------------------------------------------------------------------------
// alid_pkg
// Shared types and codes for the ordered list block: request opcodes, the
// per-cell move code and the control bundle handed to every list cell.
// ----------------------------------------------------------------------------
package alid_pkg;

    // element width
    localparam int DATA_W = 32;

    // request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // what a cell loads into its entry this cycle
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_BELOW = 2'd2,
        CELL_FROM_ABOVE = 2'd3
    } cell_op_t;

    // control bundle for one cell
    typedef struct packed {
        cell_op_t op;
        logic     bus_load;
    } cell_ctrl_t;

endpackage

/* rtl/alid_cell.sv */
// ----------------------------------------------------------------------------
// alid_cell
// One list slot: holds an entry, moves it up or down the row on insert and
// delete, and passes read data one slot towards the head every cycle.
// ----------------------------------------------------------------------------
module alid_cell
    import alid_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] below,
    input  logic signed [DATA_W-1:0] above,
    input  logic signed [DATA_W-1:0] bus_above,
    output logic signed [DATA_W-1:0] entry,
    output logic signed [DATA_W-1:0] bus
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic signed [DATA_W-1:0] bus_reg;
    logic signed [DATA_W-1:0] bus_next;

    // entry move select
    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD:       entry_next = entry_reg;
            CELL_LOAD:       entry_next = value;
            CELL_FROM_BELOW: entry_next = below;
            CELL_FROM_ABOVE: entry_next = above;
            default:         entry_next = entry_reg;
        endcase
    end

    // read bus: inject own entry when selected, else take from above
    always_comb
    begin
        bus_next = ctrl.bus_load ? entry_reg : bus_above;
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        bus_reg   <= bus_next;
    end

    assign entry = entry_reg;
    assign bus   = bus_reg;

endmodule

/* rtl/array_list_insert_delete_top.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_top
// Ordered list of signed values kept in a row of cells, with append, insert,
// delete and read requests and one result per request.
// ----------------------------------------------------------------------------
// results: append, insert, delete and any refused request set done at the
//   accepting edge itself; a read at position p gives done once its entry reaches the head
// throughput: one request per cycle except reads, which hold busy while the read
//   bus carries the entry one cell per cycle to the head
// reset: rst_n clears the length, the sequencer and done; entries are not reset
// results are strobed on done for one cycle and cannot be stalled
module array_list_insert_delete_top
    import alid_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               operation,
    input  logic [6:0]               position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic                     ok,
    output logic [7:0]               count,
    output logic signed [DATA_W-1:0] read_value
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > 7) ? FW : 7;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [FW-1:0]            fill_reg;
    logic [FW-1:0]            fill_next;
    logic [6:0]               cnt_reg;
    logic [6:0]               cnt_next;
    logic                     done_reg;
    logic                     done_next;
    logic                     ok_reg;
    logic                     ok_next;
    logic [7:0]               count_reg;
    logic [7:0]               count_next;
    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] rd_next;

    logic                     accept;
    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            fill_ext;
    logic                     not_full;
    logic                     pos_valid;
    logic                     app_ok;
    logic                     ins_ok;
    logic                     del_ok;
    logic                     rd_ok;

    cell_ctrl_t               ctrl    [CAPACITY];
    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic signed [DATA_W-1:0] bus_w   [CAPACITY];

    // request decode
    assign accept    = start && (state_reg == ST_IDLE);
    assign pos_ext   = CW'(position);
    assign fill_ext  = CW'(fill_reg);
    assign not_full  = (fill_ext < CW'(CAPACITY));
    assign pos_valid = (pos_ext < fill_ext);
    assign app_ok    = accept && (operation == OP_APPEND) && not_full;
    assign ins_ok    = accept && (operation == OP_INSERT) && pos_valid && not_full;
    assign del_ok    = accept && (operation == OP_DELETE) && pos_valid;
    assign rd_ok     = accept && (operation == OP_READ) && pos_valid;

    // per-cell move and bus control
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX  = CW'(i);
        localparam logic [CW-1:0] IDX1 = CW'(i + 1);

        logic signed [DATA_W-1:0] below_w;
        logic signed [DATA_W-1:0] above_w;
        logic signed [DATA_W-1:0] bus_above_w;

        always_comb
        begin
            ctrl[i].bus_load = rd_ok && (IDX == pos_ext);
            priority if (app_ok && (IDX == fill_ext))
                ctrl[i].op = CELL_LOAD;
            else if (ins_ok && (IDX == pos_ext))
                ctrl[i].op = CELL_LOAD;
            else if (ins_ok && (IDX > pos_ext) && (IDX <= fill_ext))
                ctrl[i].op = CELL_FROM_BELOW;
            else if (del_ok && (IDX >= pos_ext) && (IDX1 < fill_ext))
                ctrl[i].op = CELL_FROM_ABOVE;
            else
                ctrl[i].op = CELL_HOLD;
        end

        // neighbours, tied off at both ends of the row
        if (i == 0)
        begin : g_head
            assign below_w = '0;
        end
        else
        begin : g_mid_lo
            assign below_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign above_w     = '0;
            assign bus_above_w = '0;
        end
        else
        begin : g_mid_hi
            assign above_w     = entry_w[i+1];
            assign bus_above_w = bus_w[i+1];
        end

        alid_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .value     (value),
            .below     (below_w),
            .above     (above_w),
            .bus_above (bus_above_w),
            .entry     (entry_w[i]),
            .bus       (bus_w[i])
        );
    end

    // sequencer, length and result register
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (app_ok || ins_ok)
                        fill_next = fill_reg + FW'(1);
                    else if (del_ok)
                        fill_next = fill_reg - FW'(1);
                    if (rd_ok)
                    begin
                        state_next = ST_READ;
                        cnt_next   = position;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        ok_next    = app_ok || ins_ok || del_ok;
                        count_next = 8'(fill_next);
                        rd_next    = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (cnt_reg == 7'd0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    count_next = 8'(fill_reg);
                    rd_next    = bus_w[0];
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        ok_reg    <= ok_next;
        count_reg <= count_next;
        rd_reg    <= rd_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign count      = count_reg;
    assign read_value = rd_reg;

    // length never passes capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("list length above capacity");

    // a result never shows while a read is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done while busy");

    // an accepted valid read starts the bus walk, no immediate result
    a_read_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ok |=> (busy && !done_reg))
        else $error("valid read did not start bus walk");

    // the list length holds during a read walk
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(fill_reg))
        else $error("length changed during read");

endmodule

/* bench/array_list_insert_delete_top_test.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_top_test
// Self-checking bench for the ordered list block. Requests go in over the
// start/busy handshake. A scoreboard keeps its own copy of the list, works
// out the result of each accepted request and checks every done strobe
// against the oldest outstanding one. A short directed run covers the empty
// list, extreme values and the refusal cases. A phased random run then
// fills the list to capacity and drains it again, with bursts of idle
// cycles between requests.
// ----------------------------------------------------------------------------
module array_list_insert_delete_top_test;

    import alid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 128;

    typedef struct {
        logic                     ok;
        logic [7:0]               count;
        logic signed [DATA_W-1:0] read_value;
    } list_result_t;

    // request mix of the random run
    typedef enum {
        MIX_GROW,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the list and the queue of outstanding results
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [DATA_W-1:0] entries [LIST_DEPTH];
        int unsigned              fill;
        list_result_t             awaited_results [$];
        int unsigned              errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // apply an accepted request to the list and queue its result
        function void note_request(logic [1:0] op, logic [6:0] pos,
                                   logic signed [DATA_W-1:0] val);
            list_result_t res;
            res.ok         = 1'b0;
            res.read_value = '0;
            case (op)
                OP_APPEND:
                begin
                    if (fill < LIST_DEPTH)
                    begin
                        entries[fill] = val;
                        fill++;
                        res.ok = 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    // insert never appends: position must hold an entry
                    if (pos < fill && fill < LIST_DEPTH)
                    begin
                        for (int j = fill; j > pos; j--)
                            entries[j] = entries[j-1];
                        entries[pos] = val;
                        fill++;
                        res.ok = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (pos < fill)
                    begin
                        for (int j = pos; j + 1 < fill; j++)
                            entries[j] = entries[j+1];
                        fill--;
                        res.ok = 1'b1;
                    end
                end
                default:
                begin
                    if (pos < fill)
                    begin
                        res.read_value = entries[pos];
                        res.ok         = 1'b1;
                    end
                end
            endcase
            res.count = 8'(fill);
            awaited_results.push_back(res);
        endfunction

        // compare one strobed result with the oldest outstanding one
        function void check_result(logic got_ok, logic [7:0] got_count,
                                   logic signed [DATA_W-1:0] got_value);
            list_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding: ok %0d count %0d value %0d",
                       got_ok, got_count, got_value);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got_ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, got_ok);
                errors++;
            end
            if (got_count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got_count);
                errors++;
            end
            if (got_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d", want.read_value, got_value);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               operation = OP_APPEND;
    logic [6:0]               position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic                     ok;
    logic [7:0]               count;
    logic signed [DATA_W-1:0] read_value;

    list_scoreboard ledger;

    array_list_insert_delete_top #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .position   (position),
        .value      (value),
        .done       (done),
        .ok         (ok),
        .count      (count),
        .read_value (read_value)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result monitor, sampled at the edge that ends the strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(ok, count, read_value);
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] op, input logic [6:0] pos,
                                input logic signed [DATA_W-1:0] val);
        operation <= op;
        position  <= pos;
        value     <= val;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_request(op, pos, val);
    endtask

    // idle cycles with junk on the request fields
    task automatic pause_requests(input int unsigned cycles);
        start     <= 1'b0;
        operation <= 2'($urandom);
        position  <= 7'($urandom);
        value     <= $urandom;
        repeat (cycles)
            @(posedge clk);
    endtask

    // value with a bias towards the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random request, weighted by the mix and aimed at the live part of the list
    task automatic pick_request(input mix_t mix, output logic [1:0] op,
                                output logic [6:0] pos);
        int unsigned roll;
        int unsigned len;
        roll = $urandom_range(0, 99);
        len  = ledger.fill;
        case (mix)
            MIX_GROW:
                op = roll < 50 ? OP_APPEND : roll < 80 ? OP_INSERT :
                     roll < 90 ? OP_DELETE : OP_READ;
            MIX_DRAIN:
                op = roll < 10 ? OP_APPEND : roll < 20 ? OP_INSERT :
                     roll < 85 ? OP_DELETE : OP_READ;
            default:
                op = 2'(roll % 4);
        endcase
        roll = $urandom_range(0, 99);
        if (op == OP_APPEND || roll < 15)
            pos = 7'($urandom_range(0, 127));
        else if (roll < 25)
            pos = len >= LIST_DEPTH ? 7'(LIST_DEPTH - 1) : 7'(len);
        else if (len > 0)
            pos = 7'($urandom_range(0, len - 1));
        else
            pos = '0;
    endtask

    // stimulus and end of run
    initial
    begin
        logic [1:0]  op;
        logic [6:0]  pos;
        int unsigned issued;
        int unsigned full_seen;
        int unsigned guard;
        bit          idling;

        ledger = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // refusals on the empty list
        send_request(OP_READ,   7'd0, 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_INSERT, 7'd0, 32'sd7);
        // extreme values
        send_request(OP_APPEND, 7'd127, {1'b0, {(DATA_W-1){1'b1}}});
        send_request(OP_APPEND, 7'd0,   {1'b1, {(DATA_W-1){1'b0}}});
        send_request(OP_APPEND, 7'd85,  32'sd0);
        send_request(OP_APPEND, 7'd42,  -32'sd1);
        // insert at the length is refused, inside the list it shifts
        send_request(OP_INSERT, 7'd4, 32'sh1234_5678);
        send_request(OP_INSERT, 7'd0, 32'sh5a5a_5a5a);
        send_request(OP_INSERT, 7'd2, 32'sha5a5_a5a5);
        // reads at the ends and beyond them
        send_request(OP_READ, 7'd0,   32'sd0);
        send_request(OP_READ, 7'd5,   32'sd0);
        send_request(OP_READ, 7'd6,   32'sd0);
        send_request(OP_READ, 7'd127, 32'sd0);
        // deletes at the ends and beyond them
        send_request(OP_DELETE, 7'd5,   32'sd0);
        send_request(OP_DELETE, 7'd0,   32'sd0);
        send_request(OP_DELETE, 7'd127, 32'sd0);
        send_request(OP_READ,   7'd2,   32'sd0);
        send_request(OP_READ,   7'd3,   32'sd0);
        send_request(OP_APPEND, 7'd0,   32'sd1);

        // random run: grow to full and stay there a while, drain, then even mix
        issued    = 0;
        full_seen = 0;
        idling    = 1'b1;
        while (issued < 460)
        begin
            mix_t mix;
            if (full_seen < 30 && issued < 320)
                mix = MIX_GROW;
            else if (issued < 380)
                mix = MIX_DRAIN;
            else
                mix = MIX_EVEN;
            if (ledger.fill == LIST_DEPTH)
                full_seen++;
            // idling is switched per stretch and off near the end
            if (issued % 40 == 0)
                idling = $urandom_range(0, 9) < 7;
            if (issued < 400 && idling && $urandom_range(0, 99) < 30)
                pause_requests($urandom_range(1, 8));
            pick_request(mix, op, pos);
            send_request(op, pos, pick_value());
            issued++;
        end
        start <= 1'b0;

        // drain the outstanding results, then watch for strays
        guard = 0;
        while (ledger.awaited_results.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8)
            @(posedge clk);
        if (ledger.awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", ledger.awaited_results.size());
            ledger.errors++;
        end

        if (ledger.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
